// File: sv/h264fu_pkg.sv
`default_nettype none
package h264fu_pkg;

    localparam int unsigned NalLengthBitsDefault = 16;
    localparam int unsigned ChunkBits            = 11;
    localparam int unsigned IdxBits              = 5;

    localparam logic [2:0] CFG_PAYLOAD_TYPE     = 3'd0;
    localparam logic [2:0] CFG_SSRC             = 3'd1;
    localparam logic [2:0] CFG_USE_TWCC         = 3'd2;
    localparam logic [2:0] CFG_TWCC_EXT_ID      = 3'd3;
    localparam logic [2:0] CFG_MAX_PACKET_BYTES = 3'd4;

    localparam logic [6:0]  RESET_PAYLOAD_TYPE = 7'd96;
    localparam logic [3:0]  RESET_TWCC_EXT_ID  = 4'd3;
    localparam logic [10:0] RESET_MAX_PACKET   = 11'd1200;

    localparam logic [10:0] ROOM_MIN = 11'd64;
    localparam logic [10:0] ROOM_MAX = 11'd1500;

    localparam logic [4:0] HDR_BYTES_BASE = 5'd12;
    localparam logic [4:0] HDR_BYTES_TWCC = 5'd20;
    localparam logic [4:0] FU_BYTES       = 5'd2;

    localparam logic [7:0] RTP_V2       = 8'h80;
    localparam logic [7:0] RTP_V2_EXT   = 8'h90;
    localparam logic [7:0] EXT_PROF_HI  = 8'hBE;
    localparam logic [7:0] EXT_PROF_LO  = 8'hDE;
    localparam logic [7:0] EXT_LEN_HI   = 8'h00;
    localparam logic [7:0] EXT_LEN_LO   = 8'h01;
    localparam logic [3:0] EXT_ELEM_LEN = 4'h1;
    localparam logic [7:0] EXT_PAD      = 8'h00;

    localparam logic [7:0] FU_A_TYPE    = 8'd28;
    localparam logic [7:0] NAL_FNRI     = 8'hE0;
    localparam logic [7:0] NAL_TYPE     = 8'h1F;
    localparam logic [7:0] FU_START     = 8'h80;
    localparam logic [7:0] FU_END       = 8'h40;

    typedef enum logic [1:0] {
        K_DATA,
        K_SINGLE,
        K_FRAG,
        K_SAVE
    } t_kind;

    typedef struct packed {
        logic        twcc;
        logic        marker;
        logic [6:0]  payload_type;
        logic [15:0] seq;
        logic [15:0] tseq;
        logic [31:0] timestamp;
        logic [31:0] ssrc;
        logic [3:0]  ext_id;
    } t_hdr_info;

endpackage
`default_nettype wire

// File: sv/h264fu_hdr_mux.sv
`default_nettype none
module h264fu_hdr_mux (
    input  wire  [h264fu_pkg::IdxBits-1:0] i_idx,
    input  wire  h264fu_pkg::t_hdr_info    i_info,
    output logic [7:0]                     o_byte
);
    import h264fu_pkg::*;

    always_comb begin
        case (i_idx)
            5'd0:    o_byte = i_info.twcc ? RTP_V2_EXT : RTP_V2;
            5'd1:    o_byte = {i_info.marker, i_info.payload_type};
            5'd2:    o_byte = i_info.seq[15:8];
            5'd3:    o_byte = i_info.seq[7:0];
            5'd4:    o_byte = i_info.timestamp[31:24];
            5'd5:    o_byte = i_info.timestamp[23:16];
            5'd6:    o_byte = i_info.timestamp[15:8];
            5'd7:    o_byte = i_info.timestamp[7:0];
            5'd8:    o_byte = i_info.ssrc[31:24];
            5'd9:    o_byte = i_info.ssrc[23:16];
            5'd10:   o_byte = i_info.ssrc[15:8];
            5'd11:   o_byte = i_info.ssrc[7:0];
            5'd12:   o_byte = EXT_PROF_HI;
            5'd13:   o_byte = EXT_PROF_LO;
            5'd14:   o_byte = EXT_LEN_HI;
            5'd15:   o_byte = EXT_LEN_LO;
            5'd16:   o_byte = {i_info.ext_id, EXT_ELEM_LEN};
            5'd17:   o_byte = i_info.tseq[15:8];
            5'd18:   o_byte = i_info.tseq[7:0];
            5'd19:   o_byte = EXT_PAD;
            default: o_byte = EXT_PAD;
        endcase
    end

endmodule
`default_nettype wire

// File: sv/h264_rtp_fu_a_packetizer.sv
`default_nettype none
// Channel | Dir | tdata (low bit up)                         | tuser                  | tlast
// s_      | in  | data_byte, nal_length, timestamp, zero pad | marker                 | -
// m_      | out | out_byte, packet_length, zero pad          | packet_start, pkt_end  | last
// cfg     | in  | i_cfg_idx selects register, i_cfg_data value, i_cfg_we write strobe
//
// One output byte per cycle while input is available and i_m_tready is high. An
// input byte gives one payload byte; a single-NAL packet start puts the RTP header
// (12 or 20 bytes) before it, and a fragment start the header and the two FU bytes.
// A fragmented NAL header byte gives no output. The item and output registers overlap,
// so the next item is taken in the cycle its predecessor's last byte is registered.
// Synchronous active-low reset; o_s_tready follows i_m_tready combinationally.
module h264_rtp_fu_a_packetizer #(
    parameter int unsigned NAL_LENGTH_BITS = h264fu_pkg::NalLengthBitsDefault
) (
    input  wire                                     i_clk,
    input  wire                                     i_rst_n,
    input  wire                                     i_s_tvalid,
    output logic                                    o_s_tready,
    // data_byte, nal_length, timestamp, zero pad
    input  wire  [((40+NAL_LENGTH_BITS+7)/8)*8-1:0] i_s_tdata,
    // marker
    input  wire                                     i_s_tuser,
    output logic                                    o_m_tvalid,
    input  wire                                     i_m_tready,
    // out_byte, packet_length, zero pad
    output logic [23:0]                             o_m_tdata,
    // packet_start, packet_end
    output logic [1:0]                              o_m_tuser,
    output logic                                    o_m_tlast,
    input  wire                                     i_cfg_we,
    input  wire  [2:0]                              i_cfg_idx,
    input  wire  [31:0]                             i_cfg_data
);
    import h264fu_pkg::*;

    localparam int unsigned NB = NAL_LENGTH_BITS;
    localparam int unsigned CW = ((NB > ChunkBits) ? NB : ChunkBits) + 1;

    logic [6:0]  r_pt;
    logic [31:0] r_ssrc;
    logic        r_twcc;
    logic [3:0]  r_ext_id;
    logic [10:0] r_max_pkt;

    logic [15:0] r_seq, n_seq;
    logic [15:0] r_tseq, n_tseq;
    logic [NB-1:0] r_pos, n_pos;
    logic [10:0] r_chunk, n_chunk;
    logic [7:0]  r_saved, n_saved;
    logic        r_frag, n_frag;
    logic        r_ffp, n_ffp;
    logic [10:0] r_pkt_bytes, n_pkt_bytes;
    logic        r_final, n_final;

    logic          r_wv;
    logic [7:0]    r_byte;
    logic [NB-1:0] r_len;
    logic [31:0]   r_ts;
    logic          r_mk;
    logic [IdxBits-1:0] r_idx;

    logic        r_ov;
    logic [7:0]  r_obyte;
    logic [10:0] r_oplen;
    logic        r_ostart;
    logic        r_oend;
    logic        r_olast;

    logic [NB-1:0] len1;
    logic [10:0]   room;
    logic [4:0]    hdr_sz;
    logic [10:0]   pay_s;
    logic [10:0]   pay_f;
    logic [NB-1:0] remaining;
    logic [10:0]   chunk_f;
    logic          fin;
    t_kind         kind;
    logic [10:0]   chunk_pre;
    logic [10:0]   chunk_after;
    logic          end_pkt;
    logic          frag_new;
    logic          final_new;
    logic [10:0]   plen_new;
    logic          hdr_on;
    logic [IdxBits-1:0] nres_m1;
    logic [IdxBits-1:0] fu_idx;
    logic          out_adv;
    logic          emit;
    logic          done;
    logic          accept;
    t_hdr_info     hinfo;
    logic [7:0]    hdr_byte;
    logic [7:0]    res_byte;
    logic [7:0]    fu_hdr;

    assign len1 = (r_len == '0) ? NB'(1) : r_len;

    always_comb begin
        room = r_max_pkt;
        if (r_max_pkt < ROOM_MIN) begin
            room = ROOM_MIN;
        end else if (r_max_pkt > ROOM_MAX) begin
            room = ROOM_MAX;
        end
    end

    assign hdr_sz = r_twcc ? HDR_BYTES_TWCC : HDR_BYTES_BASE;
    assign pay_s  = room - 11'(hdr_sz);
    assign pay_f  = pay_s - 11'(FU_BYTES);

    assign remaining = (len1 > r_pos) ? (len1 - r_pos) : NB'(1);
    assign chunk_f = (CW'(remaining) < CW'(pay_f)) ? 11'(remaining) : pay_f;
    assign fin     = (CW'(chunk_f) == CW'(remaining));

    always_comb begin
        if (r_pos == '0) begin
            kind = (CW'(len1) <= CW'(pay_s)) ? K_SINGLE : K_SAVE;
        end else if (r_frag && (r_chunk == '0)) begin
            kind = K_FRAG;
        end else begin
            kind = K_DATA;
        end
    end

    always_comb begin
        case (kind)
            K_SINGLE: begin
                chunk_pre = 11'(len1);
                frag_new  = 1'b0;
                final_new = r_final;
                plen_new  = 11'(hdr_sz) + 11'(len1);
                hdr_on    = 1'b1;
                nres_m1   = hdr_sz;
            end
            K_FRAG: begin
                chunk_pre = chunk_f;
                frag_new  = 1'b1;
                final_new = fin;
                plen_new  = 11'(hdr_sz) + 11'(FU_BYTES) + chunk_f;
                hdr_on    = 1'b1;
                nres_m1   = hdr_sz + FU_BYTES;
            end
            default: begin
                chunk_pre = r_chunk;
                frag_new  = r_frag;
                final_new = r_final;
                plen_new  = r_pkt_bytes;
                hdr_on    = 1'b0;
                nres_m1   = '0;
            end
        endcase
    end

    assign chunk_after = (chunk_pre != '0) ? (chunk_pre - 11'd1) : '0;
    assign end_pkt     = (chunk_after == '0);
    assign fu_idx      = hdr_sz;

    always_comb begin
        n_seq       = r_seq;
        n_tseq      = r_tseq;
        n_pos       = r_pos;
        n_chunk     = r_chunk;
        n_saved     = r_saved;
        n_frag      = r_frag;
        n_ffp       = r_ffp;
        n_pkt_bytes = r_pkt_bytes;
        n_final     = r_final;
        if (kind == K_SAVE) begin
            n_saved = r_byte;
            n_frag  = 1'b1;
            n_ffp   = 1'b1;
            n_chunk = '0;
            n_final = 1'b0;
            n_pos   = NB'(1);
        end else begin
            if (hdr_on) begin
                n_seq = r_seq + 16'd1;
                if (r_twcc) begin
                    n_tseq = r_tseq + 16'd1;
                end
            end
            n_chunk     = chunk_after;
            n_pkt_bytes = plen_new;
            if (end_pkt && (!frag_new || final_new)) begin
                n_pos   = '0;
                n_frag  = 1'b0;
                n_ffp   = 1'b1;
                n_final = 1'b0;
            end else begin
                n_pos   = r_pos + NB'(1);
                n_frag  = frag_new;
                n_ffp   = (kind == K_FRAG) ? 1'b0 : r_ffp;
                n_final = final_new;
            end
        end
    end

    assign hinfo.twcc         = r_twcc;
    assign hinfo.marker       = (kind == K_FRAG) ? (r_mk & fin) : r_mk;
    assign hinfo.payload_type = r_pt;
    assign hinfo.seq          = r_seq;
    assign hinfo.tseq         = r_tseq;
    assign hinfo.timestamp    = r_ts;
    assign hinfo.ssrc         = r_ssrc;
    assign hinfo.ext_id       = r_ext_id;

    h264fu_hdr_mux u_hdr_mux (
        .i_idx  (r_idx),
        .i_info (hinfo),
        .o_byte (hdr_byte)
    );

    always_comb begin
        if (r_ffp) begin
            fu_hdr = FU_START | (r_saved & NAL_TYPE);
        end else if (fin) begin
            fu_hdr = FU_END | (r_saved & NAL_TYPE);
        end else begin
            fu_hdr = r_saved & NAL_TYPE;
        end
    end

    always_comb begin
        if (r_idx == nres_m1) begin
            res_byte = r_byte;
        end else if (r_idx < fu_idx) begin
            res_byte = hdr_byte;
        end else if (r_idx == fu_idx) begin
            res_byte = (r_saved & NAL_FNRI) | FU_A_TYPE;
        end else begin
            res_byte = fu_hdr;
        end
    end

    assign out_adv    = !r_ov || i_m_tready;
    assign emit       = r_wv && (kind != K_SAVE) && out_adv;
    assign done       = r_wv && ((kind == K_SAVE) || (emit && (r_idx == nres_m1)));
    assign o_s_tready = !r_wv || done;
    assign accept     = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pt      <= RESET_PAYLOAD_TYPE;
            r_ssrc    <= '0;
            r_twcc    <= 1'b0;
            r_ext_id  <= RESET_TWCC_EXT_ID;
            r_max_pkt <= RESET_MAX_PACKET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_PAYLOAD_TYPE:     r_pt      <= i_cfg_data[6:0];
                CFG_SSRC:             r_ssrc    <= i_cfg_data;
                CFG_USE_TWCC:         r_twcc    <= i_cfg_data[0];
                CFG_TWCC_EXT_ID:      r_ext_id  <= i_cfg_data[3:0];
                CFG_MAX_PACKET_BYTES: r_max_pkt <= i_cfg_data[10:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq       <= 16'd1;
            r_tseq      <= 16'd1;
            r_pos       <= '0;
            r_chunk     <= '0;
            r_saved     <= '0;
            r_frag      <= 1'b0;
            r_ffp       <= 1'b1;
            r_pkt_bytes <= '0;
            r_final     <= 1'b0;
        end else if (done) begin
            r_seq       <= n_seq;
            r_tseq      <= n_tseq;
            r_pos       <= n_pos;
            r_chunk     <= n_chunk;
            r_saved     <= n_saved;
            r_frag      <= n_frag;
            r_ffp       <= n_ffp;
            r_pkt_bytes <= n_pkt_bytes;
            r_final     <= n_final;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wv  <= 1'b0;
            r_idx <= '0;
        end else begin
            if (accept) begin
                r_wv <= 1'b1;
            end else if (done) begin
                r_wv <= 1'b0;
            end
            if (done) begin
                r_idx <= '0;
            end else if (emit) begin
                r_idx <= r_idx + IdxBits'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_byte <= i_s_tdata[7:0];
            r_len  <= i_s_tdata[8 +: NB];
            r_ts   <= i_s_tdata[8+NB +: 32];
            r_mk   <= i_s_tuser;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (out_adv) begin
            r_ov <= emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_obyte  <= res_byte;
            r_oplen  <= plen_new;
            r_ostart <= hdr_on && (r_idx == '0);
            r_oend   <= (r_idx == nres_m1) && end_pkt;
            r_olast  <= (r_idx == nres_m1);
        end
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = {5'b0, r_oplen, r_obyte};
    assign o_m_tuser  = {r_oend, r_ostart};
    assign o_m_tlast  = r_olast;

endmodule
`default_nettype wire

// File: sim/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
    import h264fu_pkg::*;

    localparam int NLB          = NalLengthBitsDefault;
    localparam int S_W          = ((40 + NLB + 7) / 8) * 8;
    localparam int DRAIN_CYCLES = 40;
    localparam int STALL_LIMIT  = 5000;

    typedef struct packed {
        logic [7:0]  octet;
        logic [10:0] plen;
        logic        sop;
        logic        eop;
        logic        lst;
    } t_pkt_byte;

    logic             i_clk;
    logic             i_rst_n  = 1'b0;
    logic             s_tvalid = 1'b0;
    logic [S_W-1:0]   s_tdata  = '0;
    logic             s_tuser  = 1'b0;
    logic             m_tready = 1'b0;
    logic             cfg_we   = 1'b0;
    logic [2:0]       cfg_idx  = CFG_PAYLOAD_TYPE;
    logic [31:0]      cfg_data = '0;
    wire              s_tready;
    wire              m_tvalid;
    wire  [23:0]      m_tdata;
    wire  [1:0]       m_tuser;
    wire              m_tlast;

    // packetizer state and register copies
    logic [6:0]  cfg_pt;
    logic [31:0] cfg_ssrc;
    logic        cfg_twcc;
    logic [3:0]  cfg_ext;
    logic [10:0] cfg_max;
    logic [15:0] rtp_seq;
    logic [15:0] tw_seq;
    logic [15:0] nal_pos;
    logic [10:0] chunk_left;
    logic [7:0]  saved_hdr;
    logic        frag;
    logic        first_pend;
    logic [10:0] pkt_len;
    logic        final_frag;

    t_pkt_byte   pkt_bytes_due[$];
    t_pkt_byte   pend_b;
    t_pkt_byte   want_b;
    logic        have_pend;
    int          errors      = 0;
    int          n_sent      = 0;
    int          hold_cycles = 0;
    int          idle_count  = 0;
    logic        quiet       = 1'b0;

    h264_rtp_fu_a_packetizer dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser),
        .o_m_tlast  (m_tlast),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic void emit(logic [7:0] v, logic st, logic en);
        if (have_pend) pkt_bytes_due.push_back(pend_b);
        pend_b    = '{octet: v, plen: pkt_len, sop: st, eop: en, lst: 1'b0};
        have_pend = 1'b1;
    endfunction

    function automatic void emit_header(logic [31:0] ts, logic mk);
        logic [15:0] seq;
        logic [15:0] tseq;
        seq     = rtp_seq;
        rtp_seq = rtp_seq + 16'd1;
        emit(cfg_twcc ? RTP_V2_EXT : RTP_V2, 1'b1, 1'b0);
        emit({mk, cfg_pt}, 1'b0, 1'b0);
        emit(seq[15:8], 1'b0, 1'b0);
        emit(seq[7:0], 1'b0, 1'b0);
        emit(ts[31:24], 1'b0, 1'b0);
        emit(ts[23:16], 1'b0, 1'b0);
        emit(ts[15:8], 1'b0, 1'b0);
        emit(ts[7:0], 1'b0, 1'b0);
        emit(cfg_ssrc[31:24], 1'b0, 1'b0);
        emit(cfg_ssrc[23:16], 1'b0, 1'b0);
        emit(cfg_ssrc[15:8], 1'b0, 1'b0);
        emit(cfg_ssrc[7:0], 1'b0, 1'b0);
        if (cfg_twcc) begin
            tseq   = tw_seq;
            tw_seq = tw_seq + 16'd1;
            emit(EXT_PROF_HI, 1'b0, 1'b0);
            emit(EXT_PROF_LO, 1'b0, 1'b0);
            emit(EXT_LEN_HI, 1'b0, 1'b0);
            emit(EXT_LEN_LO, 1'b0, 1'b0);
            emit({cfg_ext, EXT_ELEM_LEN}, 1'b0, 1'b0);
            emit(tseq[15:8], 1'b0, 1'b0);
            emit(tseq[7:0], 1'b0, 1'b0);
            emit(EXT_PAD, 1'b0, 1'b0);
        end
    endfunction

    function automatic void packetize_byte(logic [7:0] b, logic [15:0] nl, logic [31:0] ts,
                                           logic mk);
        int         len;
        int         hdr;
        int         pay;
        int         room;
        int         remaining;
        int         chunk;
        logic [7:0] fu;
        logic       e;
        have_pend = 1'b0;
        len  = (nl == 16'd0) ? 1 : int'(nl);
        room = (cfg_max < 11'd64) ? 64 : ((cfg_max > 11'd1500) ? 1500 : int'(cfg_max));
        hdr  = cfg_twcc ? int'(HDR_BYTES_TWCC) : int'(HDR_BYTES_BASE);
        if (nal_pos == 16'd0) begin
            pay = room - hdr;
            if (len <= pay) begin
                frag       = 1'b0;
                pkt_len    = 11'(hdr + len);
                chunk_left = 11'(len);
                emit_header(ts, mk);
            end else begin
                // hold the NAL header byte for the FU indicator and header
                saved_hdr  = b;
                frag       = 1'b1;
                first_pend = 1'b1;
                chunk_left = '0;
                final_frag = 1'b0;
                nal_pos    = 16'd1;
                return;
            end
        end else if (frag && chunk_left == 11'd0) begin
            remaining  = (len > int'(nal_pos)) ? len - int'(nal_pos) : 1;
            pay        = room - hdr - int'(FU_BYTES);
            chunk      = (remaining < pay) ? remaining : pay;
            final_frag = (chunk == remaining);
            pkt_len    = 11'(hdr + int'(FU_BYTES) + chunk);
            chunk_left = 11'(chunk);
            emit_header(ts, mk && final_frag);
            emit((saved_hdr & NAL_FNRI) | FU_A_TYPE, 1'b0, 1'b0);
            if (first_pend) fu = FU_START | (saved_hdr & NAL_TYPE);
            else if (final_frag) fu = FU_END | (saved_hdr & NAL_TYPE);
            else fu = saved_hdr & NAL_TYPE;
            emit(fu, 1'b0, 1'b0);
            first_pend = 1'b0;
        end
        if (chunk_left > 11'd0) chunk_left = chunk_left - 11'd1;
        e = (chunk_left == 11'd0);
        emit(b, 1'b0, e);
        nal_pos = nal_pos + 16'd1;
        if (e && (!frag || final_frag)) begin
            nal_pos    = '0;
            frag       = 1'b0;
            first_pend = 1'b1;
            final_frag = 1'b0;
        end
        pend_b.lst = 1'b1;
        pkt_bytes_due.push_back(pend_b);
        have_pend = 1'b0;
    endfunction

    function automatic void init_packetizer();
        cfg_pt     = RESET_PAYLOAD_TYPE;
        cfg_ssrc   = '0;
        cfg_twcc   = 1'b0;
        cfg_ext    = RESET_TWCC_EXT_ID;
        cfg_max    = RESET_MAX_PACKET;
        rtp_seq    = 16'd1;
        tw_seq     = 16'd1;
        nal_pos    = '0;
        chunk_left = '0;
        saved_hdr  = '0;
        frag       = 1'b0;
        first_pend = 1'b1;
        pkt_len    = '0;
        final_frag = 1'b0;
        have_pend  = 1'b0;
    endfunction

    function automatic void check_field(string what, int want, int got);
        if (want != got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) begin
            if (pkt_bytes_due.size() == 0) begin
                errors++;
                $display("%0t: unexpected transfer, expected none, actual byte %02h",
                         $time, m_tdata[7:0]);
            end else begin
                want_b = pkt_bytes_due.pop_front();
                check_field("out_byte", want_b.octet, m_tdata[7:0]);
                check_field("packet_length", want_b.plen, m_tdata[18:8]);
                check_field("packet_start", want_b.sop, m_tuser[0]);
                check_field("packet_end", want_b.eop, m_tuser[1]);
                check_field("last", want_b.lst, m_tlast);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) idle_count <= 0;
        else idle_count <= idle_count + 1;
        if (idle_count >= STALL_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin : rx_proc
        int gap;
        forever begin
            if (hold_cycles > 0) begin
                gap         = hold_cycles;
                hold_cycles = 0;
            end else begin
                gap = quiet ? 0 : $urandom_range(0, 12);
            end
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_tready <= 1'b1;
            do @(posedge i_clk); while (!m_tvalid && hold_cycles == 0);
        end
    end

    task automatic send_byte(logic [7:0] b, logic [15:0] nl, logic [31:0] ts, logic mk);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {ts, nl, b};
        s_tuser  <= mk;
        do @(posedge i_clk); while (!s_tready);
        packetize_byte(b, nl, ts, mk);
        n_sent++;
    endtask

    task automatic send_nal(int len, logic [31:0] ts, logic mk, logic [7:0] hdr);
        send_byte(hdr, 16'(len), ts, mk);
        while (nal_pos != 16'd0) send_byte(8'($urandom_range(0, 255)), 16'(len), ts, mk);
    endtask

    task automatic wait_drain();
        s_tvalid <= 1'b0;
        while (pkt_bytes_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] value);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        @(posedge i_clk);
        case (idx)
            CFG_PAYLOAD_TYPE:     cfg_pt   = value[6:0];
            CFG_SSRC:             cfg_ssrc = value;
            CFG_USE_TWCC:         cfg_twcc = value[0];
            CFG_TWCC_EXT_ID:      cfg_ext  = value[3:0];
            CFG_MAX_PACKET_BYTES: cfg_max  = value[10:0];
            default: ;
        endcase
        cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic test_single_defaults();
        send_nal(1, 32'h0000_0000, 1'b0, 8'h00);
        send_nal(0, 32'hFFFF_FFFF, 1'b1, 8'hFF);
        send_nal(3, 32'h1234_5678, 1'b1, 8'h65);
        wait_drain();
    endtask

    task automatic test_register_extremes();
        write_reg(CFG_PAYLOAD_TYPE, 32'd127);
        write_reg(CFG_SSRC, 32'hFFFF_FFFF);
        write_reg(CFG_USE_TWCC, 32'd1);
        write_reg(CFG_TWCC_EXT_ID, 32'd14);
        write_reg(CFG_MAX_PACKET_BYTES, 32'd2047);
        send_nal(2, 32'hFFFF_FFFF, 1'b1, 8'hFF);
        wait_drain();
        write_reg(CFG_PAYLOAD_TYPE, 32'd0);
        write_reg(CFG_SSRC, 32'd0);
        write_reg(CFG_TWCC_EXT_ID, 32'd15);
        write_reg(CFG_MAX_PACKET_BYTES, 32'd0);
        send_nal(1, 32'h0000_0000, 1'b0, 8'h00);
        wait_drain();
        write_reg(CFG_TWCC_EXT_ID, 32'd0);
        write_reg(CFG_SSRC, 32'hA5A5_5A5A);
        write_reg(CFG_MAX_PACKET_BYTES, 32'd1500);
        send_nal(1, 32'h8000_0001, 1'b1, 8'h41);
        wait_drain();
        write_reg(CFG_TWCC_EXT_ID, 32'd1);
        write_reg(CFG_USE_TWCC, 32'd0);
        write_reg(CFG_MAX_PACKET_BYTES, 32'd64);
        send_nal(1, 32'h7FFF_FFFE, 1'b0, 8'h9C);
        wait_drain();
    endtask

    task automatic test_length_change();
        // single packet keeps the count announced on its first byte
        send_byte(8'h41, 16'd3, 32'h0102_0304, 1'b0);
        send_byte(8'h00, 16'd1, 32'h0102_0304, 1'b1);
        send_byte(8'hFF, 16'hFFFF, 32'h0102_0304, 1'b0);
        // fragment that both starts and ends the NAL
        send_byte(8'h7C, 16'hFFFF, 32'hDEAD_BEEF, 1'b1);
        send_byte(8'h5A, 16'd2, 32'hDEAD_BEEF, 1'b1);
        send_byte(8'hE5, 16'd100, 32'h0000_00FF, 1'b0);
        send_byte(8'hA5, 16'd1, 32'h0000_00FF, 1'b1);
        wait_drain();
    endtask

    task automatic test_midnal_config();
        write_reg(CFG_USE_TWCC, 32'd1);
        send_byte(8'h65, 16'd200, 32'h5555_AAAA, 1'b1);
        wait_drain();
        write_reg(CFG_USE_TWCC, 32'd0);
        write_reg(CFG_MAX_PACKET_BYTES, 32'd1500);
        while (nal_pos != 16'd0) send_byte(8'($urandom_range(0, 255)), 16'd4, 32'h5555_AAAA, 1'b1);
        wait_drain();
    endtask

    task automatic test_backpressure();
        write_reg(CFG_MAX_PACKET_BYTES, 32'd64);
        quiet       = 1'b1;
        hold_cycles = 300;
        send_nal(90, $urandom, 1'b1, 8'($urandom_range(0, 255)));
        quiet = 1'b0;
        wait_drain();
    endtask

    task automatic test_random();
        int sent0;
        int n_nal;
        int pick;
        int len;
        sent0 = n_sent;
        n_nal = 0;
        while (n_sent - sent0 < 90) begin
            if (n_nal % 3 == 0) begin
                wait_drain();
                if ($urandom_range(0, 1)) write_reg(CFG_PAYLOAD_TYPE, $urandom_range(0, 127));
                if ($urandom_range(0, 1)) write_reg(CFG_SSRC, $urandom);
                if ($urandom_range(0, 1)) write_reg(CFG_USE_TWCC, $urandom_range(0, 1));
                if ($urandom_range(0, 1)) write_reg(CFG_TWCC_EXT_ID, $urandom_range(0, 15));
                pick = $urandom_range(0, 9);
                case (pick)
                    0: write_reg(CFG_MAX_PACKET_BYTES, 32'd64);
                    1: write_reg(CFG_MAX_PACKET_BYTES, 32'd1500);
                    2: write_reg(CFG_MAX_PACKET_BYTES, $urandom_range(0, 63));
                    3: write_reg(CFG_MAX_PACKET_BYTES, $urandom_range(1501, 2047));
                    default: write_reg(CFG_MAX_PACKET_BYTES, $urandom_range(64, 200));
                endcase
            end
            quiet = ($urandom_range(0, 3) == 0);
            pick  = $urandom_range(0, 19);
            if (pick < 3) begin
                // length field shifts under the NAL
                send_byte(8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)), $urandom,
                          1'($urandom_range(0, 1)));
                while (nal_pos != 16'd0)
                    send_byte(8'($urandom_range(0, 255)), 16'($urandom_range(0, 8)), $urandom,
                              1'($urandom_range(0, 1)));
            end else begin
                pick = $urandom_range(0, 19);
                if (pick == 0) len = 0;
                else if (pick < 12) len = $urandom_range(1, 12);
                else if (pick < 17) len = $urandom_range(13, 60);
                else len = $urandom_range(61, 130);
                send_nal(len, $urandom, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
            end
            n_nal++;
        end
        quiet = 1'b0;
    endtask

    initial begin
        init_packetizer();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_single_defaults();
        test_register_extremes();
        test_length_change();
        test_midnal_config();
        test_backpressure();
        test_random();
        wait_drain();
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// File: sim.f
sv/h264fu_pkg.sv
sv/h264fu_hdr_mux.sv
sv/h264_rtp_fu_a_packetizer.sv
sim/tb_top.sv
